FILE: hdl/ca_pkg.sv
// ----------------------------------------------------------------------------
// ca_pkg: shared types and constants of the cellular automaton grid
// Operation and rule codes, sequencer states and the control word
// that drives the row of grid cells.
// ----------------------------------------------------------------------------
package ca_pkg;

  localparam int unsigned DefGridWidth  = 64;
  localparam int unsigned DefGridHeight = 64;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_FLIP  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_STEP  = 3'd4;

  localparam logic [2:0] RULE_LIFE       = 3'd0;
  localparam logic [2:0] RULE_CONTINENTS = 3'd1;
  localparam logic [2:0] RULE_ISLANDS    = 3'd2;
  localparam logic [2:0] RULE_INSECTOID  = 3'd3;
  localparam logic [2:0] RULE_DESOLATION = 3'd4;

  localparam logic CFG_RULE_SELECT     = 1'b0;
  localparam logic CFG_UPPER_THRESHOLD = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_SWEEP,
    S_DONE
  } ca_state_t;

  typedef struct packed {
    logic grid_shift;
    logic snap_shift;
    logic snap_load;
    logic clear;
  } ca_cell_ctl_t;

endpackage

FILE: hdl/ca_cell.sv
// ----------------------------------------------------------------------------
// ca_cell: one grid cell of the ring
// Holds one live bit and one snapshot bit; each hands its value to the
// neighboring cell when its own ring rotates.
// ----------------------------------------------------------------------------
module ca_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ca_pkg::ca_cell_ctl_t  ctl,
  input  logic                  grid_in,
  input  logic                  snap_in,
  output logic                  grid_q,
  output logic                  snap_q
);
  import ca_pkg::*;

  logic grid_r;
  logic snap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= 1'b0;
    end else if (ctl.clear) begin
      grid_r <= 1'b0;
    end else if (ctl.grid_shift) begin
      grid_r <= grid_in;
    end
  end

  // The snapshot has no reset: every generation loads it before use.
  always_ff @(posedge clk) begin
    if (ctl.snap_load) begin
      snap_r <= grid_r;
    end else if (ctl.snap_shift) begin
      snap_r <= snap_in;
    end
  end

  assign grid_q = grid_r;
  assign snap_q = snap_r;

endmodule

FILE: hdl/ca_rule.sv
// ----------------------------------------------------------------------------
// ca_rule: neighbor count and rule evaluation
// Counts the live neighbors of the cell at the head of the ring and gives
// its value in the next generation under the selected rule.
// ----------------------------------------------------------------------------
module ca_rule (
  input  logic        self_val,
  input  logic [7:0]  nbr,
  input  logic [2:0]  rule_select,
  input  logic [3:0]  upper_threshold,
  output logic        next_val
);
  import ca_pkg::*;

  logic [3:0] count;

  always_comb begin
    count = 4'd0;
    for (int i = 0; i < 8; i++) begin
      count = count + {3'd0, nbr[i]};
    end
  end

  always_comb begin
    case (rule_select)
      RULE_LIFE:       next_val = self_val ? (count == 4'd2 || count == 4'd3)
                                           : (count == 4'd3);
      RULE_CONTINENTS: next_val = (count <= 4'd4);
      RULE_ISLANDS:    next_val = (count <= 4'd6);
      RULE_INSECTOID:  next_val = (count > upper_threshold) || (count < 4'd2);
      RULE_DESOLATION: next_val = (count > 4'd5);
      default:         next_val = 1'b0;
    endcase
  end

endmodule

FILE: hdl/cellular_automaton_grid_step.sv
// ----------------------------------------------------------------------------
// cellular_automaton_grid_step: one-bit cellular automaton grid
// Grid of GRID_WIDTH x GRID_HEIGHT cells held in a rotating ring of cells,
// with read, write, flip, clear and generation-step operations.
// ----------------------------------------------------------------------------
// The grid lives in a ring of GRID_WIDTH*GRID_HEIGHT small cells, each with a
// live bit and a snapshot bit, ordered by the flattened index y*GRID_WIDTH+x.
// Every beat on the input channel is one operation and gives exactly one
// result beat. Read, write and flip first reduce the flattened address modulo
// the grid size by repeated subtraction, then rotate the ring one full turn,
// one cell per cycle, touching the addressed cell as it passes the head. A
// step copies the live bits into the snapshot in the cycle the beat is
// taken, then rotates both rings one full turn; the eight neighbors of the
// head cell sit at fixed taps of the snapshot ring, so every cell gets its
// new value as it passes the head. Clear and unknown operations go straight
// to the result state. The rotation of the ring sets the rate.
// The result is held in an output register, so the next beat can be taken
// while a result still waits on out_stall. Configuration is written with
// cfg_we; register 0 is rule_select and register 1 is upper_threshold.
// ----------------------------------------------------------------------------
module cellular_automaton_grid_step #(
  parameter int unsigned GRID_WIDTH  = ca_pkg::DefGridWidth,
  parameter int unsigned GRID_HEIGHT = ca_pkg::DefGridHeight
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  input  logic        in_write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_cell_value,
  output logic [31:0] out_generation,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata
);
  import ca_pkg::*;

  // The flattened address register must hold both the largest address and
  // the grid size itself, so the modulo compare never sees a truncated size.
  localparam int unsigned N      = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned IDX_W  = $clog2(N);
  localparam int unsigned FLAT_W = $clog2(N + 63 * GRID_WIDTH + 64);
  localparam int unsigned W      = GRID_WIDTH;

  localparam logic [FLAT_W-1:0] N_FLAT    = FLAT_W'(N);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(N - 1);
  localparam logic [FLAT_W-1:0] WIDTH_CST = FLAT_W'(GRID_WIDTH);

  // Configuration registers.
  logic [2:0] rule_r;
  logic [3:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r <= RULE_LIFE;
      thr_r  <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RULE_SELECT:     rule_r <= cfg_wdata[2:0];
        CFG_UPPER_THRESHOLD: thr_r  <= cfg_wdata;
        default:             rule_r <= rule_r;
      endcase
    end
  end

  // Sequencer state.
  ca_state_t         state_r, state_nxt;
  logic [2:0]        op_r;
  logic              wval_r;
  logic [FLAT_W-1:0] flat_r, flat_nxt;
  logic [IDX_W-1:0]  k_r;
  logic [31:0]       gen_r;
  logic              res_r, res_nxt;
  logic              out_valid_r;
  logic              out_cell_r;
  logic [31:0]       out_gen_r;

  logic              in_acc;
  logic              out_free;
  logic              hit;
  logic              sweep_last;
  ca_cell_ctl_t      ctl;

  // Ring taps.
  logic [N-1:0]      grid_q;
  logic [N-1:0]      snap_q;
  logic              grid_tail;
  logic              touched;
  logic              rule_next;
  logic [7:0]        nbr;

  assign in_acc     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  assign hit        = (flat_r == {{(FLAT_W - IDX_W){1'b0}}, k_r});
  assign sweep_last = (k_r == LAST_IDX);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_READ || in_operation == OP_WRITE ||
              in_operation == OP_FLIP) begin
            state_nxt = S_MOD;
          end else if (in_operation == OP_STEP) begin
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MOD: begin
        if (flat_r < N_FLAT) begin
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output logic of the sequencer: cell ring control.
  always_comb begin
    ctl = '0;
    case (state_r)
      S_IDLE: begin
        ctl.clear     = in_acc && (in_operation == OP_CLEAR);
        ctl.snap_load = in_acc && (in_operation == OP_STEP);
      end
      S_SWEEP: begin
        ctl.grid_shift = 1'b1;
        ctl.snap_shift = (op_r == OP_STEP);
      end
      default: ctl = '0;
    endcase
  end

  // Value written back at the tail as the head cell leaves.
  always_comb begin
    case (op_r)
      OP_WRITE: touched = wval_r;
      OP_FLIP:  touched = ~grid_q[0];
      default:  touched = grid_q[0];
    endcase
  end

  assign grid_tail = (op_r == OP_STEP) ? rule_next : (hit ? touched : grid_q[0]);

  always_comb begin
    flat_nxt = flat_r;
    res_nxt  = res_r;
    if (state_r == S_IDLE && in_acc) begin
      flat_nxt = FLAT_W'(in_cell_y) * WIDTH_CST + FLAT_W'(in_cell_x);
      res_nxt  = 1'b0;
    end else if (state_r == S_MOD && flat_r >= N_FLAT) begin
      flat_nxt = flat_r - N_FLAT;
    end else if (state_r == S_SWEEP && op_r != OP_STEP && hit) begin
      res_nxt = touched;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      gen_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SWEEP) begin
        k_r <= sweep_last ? '0 : k_r + 1'b1;
        if (sweep_last && op_r == OP_STEP) begin
          gen_r <= gen_r + 32'd1;
        end
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    flat_r <= flat_nxt;
    res_r  <= res_nxt;
    if (in_acc) begin
      op_r   <= in_operation;
      wval_r <= in_write_value;
    end
    if (state_r == S_DONE && out_free) begin
      out_cell_r <= res_r;
      out_gen_r  <= gen_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_generation = out_gen_r;

  // The ring: cell j takes its neighbor j+1; the live bit of the last cell takes the tail, its snapshot takes cell 0.
  for (genvar j = 0; j < N; j++) begin : g_cell
    ca_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .grid_in ((j == N - 1) ? grid_tail : grid_q[(j + 1) % N]),
      .snap_in (snap_q[(j + 1) % N]),
      .grid_q  (grid_q[j]),
      .snap_q  (snap_q[j])
    );
  end

  // Neighbors of the head cell sit at fixed offsets around the ring.
  assign nbr = {snap_q[W + 1], snap_q[W], snap_q[W - 1], snap_q[1],
                snap_q[N - 1], snap_q[N - W + 1], snap_q[N - W], snap_q[N - W - 1]};

  ca_rule u_rule (
    .self_val        (snap_q[0]),
    .nbr             (nbr),
    .rule_select     (rule_r),
    .upper_threshold (thr_r),
    .next_val        (rule_next)
  );

  // A taken beat always leaves the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken while sequencer stayed idle");

  // The last rotation cycle always ends in the result state.
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && sweep_last) |=> (state_r == S_DONE))
    else $error("sweep did not end in result state");

  // The generation count moves only at the end of a step sweep.
  a_gen_only_step: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_r != $past(gen_r)) |-> ($past(state_r) == S_SWEEP && $past(op_r) == OP_STEP))
    else $error("generation changed outside a step");

endmodule
